// ----- hdl/psot_pkg.sv -----
// ----------------------------------------------------------------------------
// psot_pkg
// Shared constants, codes and types of the 3D point-on-segment test:
// widths, pipeline stage numbers, register indexes and verdict codes.
// ----------------------------------------------------------------------------
package psot_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int TOL_WIDTH = 31;
	localparam int LIMB_W = 32;

	// Latency of one limb multiplier: magnitude, partial products, rows, total.
	localparam int MUL_LAT = 4;

	// Stage numbers of the top-level pipeline
	localparam int STG_DIFF = 1;
	localparam int STG_MUL1 = STG_DIFF + 1;
	localparam int STG_SUM = STG_MUL1 + MUL_LAT;
	localparam int STG_MUL2 = STG_SUM + 1;
	localparam int STG_SQSUM = STG_MUL2 + MUL_LAT;
	localparam int STG_OUT = STG_SQSUM + 1;
	localparam int STAGES = STG_OUT;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_END_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_END_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TOL = 3'd6;

	// 1.0 in Q16.16
	localparam logic [63:0] END_X_RESET = 64'd65536;

	typedef enum logic [1:0] {
		VERDICT_ON = 2'd0,
		VERDICT_FAR = 2'd1,
		VERDICT_BEFORE = 2'd2,
		VERDICT_BEYOND = 2'd3
	} verdict_t;

	typedef struct packed {
		logic before_start;
		logic past_end;
		logic zero_len;
		logic far_point;
	} flags_t;

endpackage

// ----- hdl/psot_cfg.sv -----
// ----------------------------------------------------------------------------
// psot_cfg
// Configuration registers: segment start, segment end and distance
// tolerance, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module psot_cfg #(
	parameter int COORD_WIDTH = psot_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr,
	input  logic [psot_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [(COORD_WIDTH > psot_pkg::TOL_WIDTH ? COORD_WIDTH
		: psot_pkg::TOL_WIDTH)-1:0] cfg_data,
	output logic signed [COORD_WIDTH-1:0] seg_start [3],
	output logic signed [COORD_WIDTH-1:0] seg_end [3],
	output logic [psot_pkg::TOL_WIDTH-1:0] tol
);
	import psot_pkg::*;

	logic signed [COORD_WIDTH-1:0] start_q [3];
	logic signed [COORD_WIDTH-1:0] end_q [3];
	logic [TOL_WIDTH-1:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q[0] <= '0;
			start_q[1] <= '0;
			start_q[2] <= '0;
			end_q[0] <= COORD_WIDTH'(END_X_RESET);
			end_q[1] <= '0;
			end_q[2] <= '0;
			tol_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_START_X: start_q[0] <= COORD_WIDTH'(cfg_data);
				REG_START_Y: start_q[1] <= COORD_WIDTH'(cfg_data);
				REG_START_Z: start_q[2] <= COORD_WIDTH'(cfg_data);
				REG_END_X: end_q[0] <= COORD_WIDTH'(cfg_data);
				REG_END_Y: end_q[1] <= COORD_WIDTH'(cfg_data);
				REG_END_Z: end_q[2] <= COORD_WIDTH'(cfg_data);
				REG_TOL: tol_q <= TOL_WIDTH'(cfg_data);
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	assign seg_start = start_q;
	assign seg_end = end_q;
	assign tol = tol_q;

endmodule

// ----- hdl/psot_mul.sv -----
// ----------------------------------------------------------------------------
// psot_mul
// Pipelined signed multiplier built from LW x LW limb products:
// magnitude, partial products, row sums, then total with sign restored.
// ----------------------------------------------------------------------------
module psot_mul #(
	parameter int AW = psot_pkg::LIMB_W,
	parameter int BW = psot_pkg::LIMB_W,
	parameter int LW = psot_pkg::LIMB_W
) (
	input  logic clk,
	input  logic [psot_pkg::MUL_LAT-1:0] en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0] p
);
	import psot_pkg::*;

	localparam int NA = (AW + LW - 1) / LW;
	localparam int NB = (BW + LW - 1) / LW;
	localparam int AXW = NA * LW;
	localparam int BXW = NB * LW;
	localparam int RW = (NB + 1) * LW;
	localparam int SW = (NA + NB) * LW;
	localparam int PW = AW + BW;

	logic [AW-1:0] a_u, a_abs;
	logic [BW-1:0] b_u, b_abs;

	logic [AXW-1:0] a_mag_s1;
	logic [BXW-1:0] b_mag_s1;
	logic neg_s1, neg_s2, neg_s3;
	logic [2*LW-1:0] pp_s2 [NA][NB];
	logic [RW-1:0] row_c [NA];
	logic [RW-1:0] row_s3 [NA];
	logic [SW-1:0] total_c;
	logic [PW-1:0] mag_c;
	logic signed [PW-1:0] p_s4;

	assign a_u = $unsigned(a);
	assign b_u = $unsigned(b);
	assign a_abs = a[AW-1] ? (~a_u + 1'b1) : a_u;
	assign b_abs = b[BW-1] ? (~b_u + 1'b1) : b_u;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_mag_s1 <= AXW'(a_abs);
			b_mag_s1 <= BXW'(b_abs);
			neg_s1 <= a[AW-1] ^ b[BW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= a_mag_s1[i*LW +: LW] * b_mag_s1[j*LW +: LW];
				end
			end
			neg_s2 <= neg_s1;
		end
	end

	// Sum each row of limb products
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_c[i] = row_c[i] + (RW'(pp_s2[i][j]) << (j * LW));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			row_s3 <= row_c;
			neg_s3 <= neg_s2;
		end
	end

	always_comb begin
		total_c = '0;
		for (int i = 0; i < NA; i++) begin
			total_c = total_c + (SW'(row_s3[i]) << (i * LW));
		end
		mag_c = total_c[PW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			p_s4 <= neg_s3 ? (~mag_c + 1'b1) : mag_c;
		end
	end

	assign p = p_s4;

endmodule

// ----- hdl/psot_ctl.sv -----
// ----------------------------------------------------------------------------
// psot_ctl
// Pipeline control: valid bit per stage and per-stage advance enables.
// A stage loads when it is empty or when the stage after it loads.
// ----------------------------------------------------------------------------
module psot_ctl #(
	parameter int STAGES = psot_pkg::STAGES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output logic [STAGES:1] en
);
	import psot_pkg::*;

	logic [STAGES:1] vld_q;
	logic [STAGES:1] vld_in;

	assign en[STAGES] = !vld_q[STAGES] || !out_stall;

	for (genvar k = 1; k < STAGES; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	assign vld_in = {vld_q[STAGES-1:1], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (en & vld_in) | (~en & vld_q);
		end
	end

	assign in_stall = !en[1];
	assign out_valid = vld_q[STAGES];

	// Input backs up only when every stage holds an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld_q && out_stall))
		else $error("input stalled with a bubble in the pipeline");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[1])
		else $error("accepted transfer did not reach the first stage");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> ($countones(vld_q) == $past($countones(vld_q))
		+ int'($past(in_valid && !in_stall)) - int'($past(out_valid && !out_stall))))
		else $error("item lost or duplicated in the pipeline");

endmodule

// ----- hdl/point_on_segment_test_3d.sv -----
// ----------------------------------------------------------------------------
// point_on_segment_test_3d
// Tests whether each query point lies on a configured 3D segment within a
// distance tolerance (Q16.16). One point is taken every clock unless in_stall is
// high; the pipeline consists of two 4-stage limb multipliers in series
// (products of the differences, then squares of the cross product
// and tol^2*|d|^2) plus the difference, sum, square-sum and compare stages.
// Far from the line is checked first, then before the start, then beyond
// the end; a zero-length segment accepts points within tolerance of the start.
// ----------------------------------------------------------------------------
module point_on_segment_test_3d #(
	parameter int COORD_WIDTH = psot_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr,
	input  logic [psot_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [(COORD_WIDTH > psot_pkg::TOL_WIDTH ? COORD_WIDTH
		: psot_pkg::TOL_WIDTH)-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	output logic out_valid,
	input  logic out_stall,
	output logic on_segment,
	output logic [1:0] verdict
);
	import psot_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW1 = 2 * DW;
	localparam int DTW = PW1 + 2;
	localparam int DDW = PW1;
	localparam int CW = PW1 + 1;
	localparam int C2W = 2 * CW - 2;
	localparam int T2W = 2 * TOL_WIDTH;
	localparam int TDW = T2W + DDW;

	logic [STAGES:1] en;
	logic [MUL_LAT-1:0] en_m1, en_m2;

	logic signed [COORD_WIDTH-1:0] seg_start [3];
	logic signed [COORD_WIDTH-1:0] seg_end [3];
	logic [TOL_WIDTH-1:0] tol;
	logic signed [COORD_WIDTH-1:0] pt [3];

	logic signed [DW-1:0] d_s1 [3];
	logic signed [DW-1:0] p0_s1 [3];
	logic signed [DW-1:0] p1_s1 [3];
	logic [TOL_WIDTH-1:0] tol_s1;

	logic signed [PW1-1:0] crs_a_p [3];
	logic signed [PW1-1:0] crs_b_p [3];
	logic signed [PW1-1:0] dot0_p [3];
	logic signed [PW1-1:0] dot1_p [3];
	logic signed [PW1-1:0] sqd_p [3];
	logic signed [PW1-1:0] sqp_p [3];
	logic signed [2*TOL_WIDTH+1:0] tt_p;

	logic signed [DTW-1:0] dot0_sum, dot1_sum;
	logic [DDW-1:0] dd_sum, pp_sum;

	logic signed [CW-1:0] c_s6 [3];
	logic [DDW-1:0] dd_s6, pp_s6;
	logic [T2W-1:0] t2_s6;
	flags_t fl_s6, fl_s7_d, fl_s7, fl_s8, fl_s9, fl_s10, fl_s11;

	logic signed [2*CW-1:0] sqc_p [3];
	logic signed [T2W+DDW+1:0] tdd_p;

	logic [C2W-1:0] c2_s11;
	logic [TDW-1:0] tdd_s11;

	logic far_c;
	verdict_t verdict_c, verdict_s12;
	logic on_segment_s12;

	psot_cfg #(.COORD_WIDTH(COORD_WIDTH)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.seg_start (seg_start),
		.seg_end   (seg_end),
		.tol       (tol)
	);

	psot_ctl #(.STAGES(STAGES)) u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.en        (en)
	);

	assign en_m1 = en[STG_MUL1+MUL_LAT-1:STG_MUL1];
	assign en_m2 = en[STG_MUL2+MUL_LAT-1:STG_MUL2];

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	// Differences: d = E - S, p0 = P - S, p1 = P - E
	always_ff @(posedge clk) begin
		if (en[STG_DIFF]) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= DW'(seg_end[i]) - DW'(seg_start[i]);
				p0_s1[i] <= DW'(pt[i]) - DW'(seg_start[i]);
				p1_s1[i] <= DW'(pt[i]) - DW'(seg_end[i]);
			end
			tol_s1 <= tol;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_axis
		psot_mul #(.AW(DW), .BW(DW), .LW(LIMB_W)) u_crs_a (
			.clk (clk), .en (en_m1),
			.a (p0_s1[(i+1)%3]), .b (d_s1[(i+2)%3]), .p (crs_a_p[i])
		);
		psot_mul #(.AW(DW), .BW(DW), .LW(LIMB_W)) u_crs_b (
			.clk (clk), .en (en_m1),
			.a (p0_s1[(i+2)%3]), .b (d_s1[(i+1)%3]), .p (crs_b_p[i])
		);
		psot_mul #(.AW(DW), .BW(DW), .LW(LIMB_W)) u_dot0 (
			.clk (clk), .en (en_m1),
			.a (p0_s1[i]), .b (d_s1[i]), .p (dot0_p[i])
		);
		psot_mul #(.AW(DW), .BW(DW), .LW(LIMB_W)) u_dot1 (
			.clk (clk), .en (en_m1),
			.a (p1_s1[i]), .b (d_s1[i]), .p (dot1_p[i])
		);
		psot_mul #(.AW(DW), .BW(DW), .LW(LIMB_W)) u_sqd (
			.clk (clk), .en (en_m1),
			.a (d_s1[i]), .b (d_s1[i]), .p (sqd_p[i])
		);
		psot_mul #(.AW(DW), .BW(DW), .LW(LIMB_W)) u_sqp (
			.clk (clk), .en (en_m1),
			.a (p0_s1[i]), .b (p0_s1[i]), .p (sqp_p[i])
		);
		psot_mul #(.AW(CW), .BW(CW), .LW(LIMB_W)) u_sqc (
			.clk (clk), .en (en_m2),
			.a (c_s6[i]), .b (c_s6[i]), .p (sqc_p[i])
		);
	end

	psot_mul #(.AW(TOL_WIDTH+1), .BW(TOL_WIDTH+1), .LW(LIMB_W)) u_tol (
		.clk (clk), .en (en_m1),
		.a ({1'b0, tol_s1}), .b ({1'b0, tol_s1}), .p (tt_p)
	);

	psot_mul #(.AW(T2W+1), .BW(DDW+1), .LW(LIMB_W)) u_tdd (
		.clk (clk), .en (en_m2),
		.a ({1'b0, t2_s6}), .b ({1'b0, dd_s6}), .p (tdd_p)
	);

	always_comb begin
		dot0_sum = DTW'(dot0_p[0]) + DTW'(dot0_p[1]) + DTW'(dot0_p[2]);
		dot1_sum = DTW'(dot1_p[0]) + DTW'(dot1_p[1]) + DTW'(dot1_p[2]);
		dd_sum = DDW'(sqd_p[0]) + DDW'(sqd_p[1]) + DDW'(sqd_p[2]);
		pp_sum = DDW'(sqp_p[0]) + DDW'(sqp_p[1]) + DDW'(sqp_p[2]);
	end

	// Cross product, dot products, |d|^2 and |p0|^2
	always_ff @(posedge clk) begin
		if (en[STG_SUM]) begin
			for (int i = 0; i < 3; i++) begin
				c_s6[i] <= CW'(crs_a_p[i]) - CW'(crs_b_p[i]);
			end
			dd_s6 <= dd_sum;
			pp_s6 <= pp_sum;
			t2_s6 <= tt_p[T2W-1:0];
			fl_s6.before_start <= dot0_sum[DTW-1];
			fl_s6.past_end <= !dot1_sum[DTW-1] && (dot1_sum != '0);
			fl_s6.zero_len <= (dd_sum == '0);
			fl_s6.far_point <= 1'b0;
		end
	end

	// Distance to the start, used only for a zero-length segment
	always_comb begin
		fl_s7_d = fl_s6;
		fl_s7_d.far_point = (pp_s6 > t2_s6);
	end

	always_ff @(posedge clk) begin
		if (en[STG_MUL2]) fl_s7 <= fl_s7_d;
		if (en[STG_MUL2+1]) fl_s8 <= fl_s7;
		if (en[STG_MUL2+2]) fl_s9 <= fl_s8;
		if (en[STG_MUL2+3]) fl_s10 <= fl_s9;
	end

	always_ff @(posedge clk) begin
		if (en[STG_SQSUM]) begin
			c2_s11 <= sqc_p[0][C2W-1:0] + sqc_p[1][C2W-1:0] + sqc_p[2][C2W-1:0];
			tdd_s11 <= tdd_p[TDW-1:0];
			fl_s11 <= fl_s10;
		end
	end

	always_comb begin
		far_c = fl_s11.zero_len ? fl_s11.far_point : (c2_s11 > tdd_s11);
		if (far_c) begin
			verdict_c = VERDICT_FAR;
		end else if (fl_s11.before_start) begin
			verdict_c = VERDICT_BEFORE;
		end else if (fl_s11.past_end) begin
			verdict_c = VERDICT_BEYOND;
		end else begin
			verdict_c = VERDICT_ON;
		end
	end

	always_ff @(posedge clk) begin
		if (en[STG_OUT]) begin
			verdict_s12 <= verdict_c;
			on_segment_s12 <= (verdict_c == VERDICT_ON);
		end
	end

	assign verdict = verdict_s12;
	assign on_segment = on_segment_s12;

endmodule
